// ----- hw/rtl/pol_pkg.sv -----
// Package for the positional ordered list: sizes, operation and status codes,
// and the control bundle that the top level broadcasts to the cell chain.
// No dependencies.
package pol_pkg;

    localparam int CAPACITY = 16;
    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  pidx;
        logic [IDX_W-1:0]  tail_idx;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/pol_ifs.sv -----
// Handshake channels of the positional ordered list: request and response.
// Depends on pol_pkg for field widths.
interface pol_req_if;
    logic                            valid;
    logic                            ready;
    logic [pol_pkg::OP_W-1:0]        operation;
    logic [pol_pkg::POS_W-1:0]       position;
    logic signed [pol_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

interface pol_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pol_pkg::STAT_W-1:0]        status;
    logic signed [pol_pkg::DATA_W-1:0] entry_value;
    logic [pol_pkg::ECNT_W-1:0]        element_count;
    logic                              last_result;

    modport source (output valid, output status, output entry_value,
                    output element_count, output last_result, input ready);
    modport sink   (input valid, input status, input entry_value,
                    input element_count, input last_result, output ready);
endinterface

// ----- hw/rtl/pol_cell.sv -----
// One storage cell of the list chain: holds one entry and loads from its left
// or right neighbor, the new value, or the head cell. Depends on pol_pkg.
module pol_cell
(
    input  logic                       clk,
    input  pol_pkg::cell_ctl_t         ctl,
    input  logic [pol_pkg::IDX_W-1:0]  index,
    input  logic [pol_pkg::DATA_W-1:0] left,
    input  logic [pol_pkg::DATA_W-1:0] right,
    input  logic [pol_pkg::DATA_W-1:0] head,
    output logic [pol_pkg::DATA_W-1:0] data
);

    logic [pol_pkg::DATA_W-1:0] data_reg;
    logic [pol_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.mode)
            pol_pkg::MODE_INSERT:
            begin
                if (index > ctl.pidx)
                    data_next = left;
                else if (index == ctl.pidx)
                    data_next = ctl.value;
            end
            pol_pkg::MODE_DELETE:
            begin
                if (index >= ctl.pidx)
                    data_next = right;
            end
            pol_pkg::MODE_ROTATE:
            begin
                // wrap the head around to the current tail
                if (index == ctl.tail_idx)
                    data_next = head;
                else
                    data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- hw/rtl/positional_ordered_list_core.sv -----
// Top level of the positional ordered list: request decode, count, dump
// sequencer, response register and the chain of pol_cell entries.
// Depends on pol_pkg, pol_ifs and pol_cell.
//
// Usage:
//   req carries operation, position and value; rsp returns status,
//   entry_value, element_count and last_result, one or more items per request.
//   Insert and delete shift the entries from the position on in the cycle the
//   request is taken; one response item is registered in the next cycle.
//   A dump rotates the chain once per response item, putting out the head
//   entry each time; after count rotations the list is back in order. A dump
//   of n entries gives n items, one per cycle while the receiver takes them.
//   A dump goes to ST_DUMP when taken and registers its first item there;
//   a dump of an empty list gives a single item, as the other requests do.
//   One request is in work at a time: req.ready is high only while no dump
//   runs and the response register is empty or being drained.
//   When rsp.ready is low the response register holds its item and the dump
//   rotation stops until it is taken.
//   Reset empties the list and the response register; entries are not
//   cleared and are never read before being written.
module positional_ordered_list_core
(
    input  logic     clk,
    input  logic     rst_n,
    pol_req_if.sink  req,
    pol_rsp_if.source rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                         state_reg;
    logic                         state_next;
    logic [pol_pkg::CNT_W-1:0]    count_reg;
    logic [pol_pkg::CNT_W-1:0]    count_next;
    logic [pol_pkg::CNT_W-1:0]    rem_reg;
    logic [pol_pkg::CNT_W-1:0]    rem_next;

    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic [pol_pkg::STAT_W-1:0]   rsp_status_reg;
    logic [pol_pkg::STAT_W-1:0]   rsp_status_next;
    logic [pol_pkg::DATA_W-1:0]   rsp_value_reg;
    logic [pol_pkg::DATA_W-1:0]   rsp_value_next;
    logic [pol_pkg::CNT_W-1:0]    rsp_count_reg;
    logic [pol_pkg::CNT_W-1:0]    rsp_count_next;
    logic                         rsp_last_reg;
    logic                         rsp_last_next;

    logic                         slot_free;
    logic                         accept;
    logic [pol_pkg::CMP_W-1:0]    pos_ext;
    logic [pol_pkg::CMP_W-1:0]    cnt_ext;
    pol_pkg::cell_ctl_t           ctl;
    logic [pol_pkg::DATA_W-1:0]   cells [pol_pkg::CAPACITY];

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign pos_ext   = pol_pkg::CMP_W'(req.position);
    assign cnt_ext   = pol_pkg::CMP_W'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_last_next   = rsp_last_reg;
        ctl.mode        = pol_pkg::MODE_HOLD;
        ctl.pidx        = pol_pkg::IDX_W'(pos_ext - pol_pkg::CMP_W'(1));
        ctl.tail_idx    = pol_pkg::IDX_W'(count_reg - pol_pkg::CNT_W'(1));
        ctl.value       = req.value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = '0;
                    rsp_last_next   = 1'b1;
                    rsp_count_next  = count_reg;
                    rsp_status_next = pol_pkg::ST_BADPOS;
                    case (req.operation)
                        pol_pkg::OP_INSERT:
                        begin
                            if (count_reg >= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
                                rsp_status_next = pol_pkg::ST_FULL;
                            else if (pos_ext != '0 && pos_ext <= cnt_ext + pol_pkg::CMP_W'(1))
                            begin
                                ctl.mode        = pol_pkg::MODE_INSERT;
                                count_next      = count_reg + pol_pkg::CNT_W'(1);
                                rsp_count_next  = count_next;
                                rsp_status_next = pol_pkg::ST_OK;
                            end
                        end
                        pol_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                                rsp_status_next = pol_pkg::ST_EMPTY;
                            else if (pos_ext != '0 && pos_ext <= cnt_ext)
                            begin
                                ctl.mode        = pol_pkg::MODE_DELETE;
                                count_next      = count_reg - pol_pkg::CNT_W'(1);
                                rsp_count_next  = count_next;
                                rsp_status_next = pol_pkg::ST_OK;
                            end
                        end
                        pol_pkg::OP_DUMP:
                        begin
                            if (count_reg == '0)
                                rsp_status_next = pol_pkg::ST_EMPTY;
                            else
                            begin
                                rsp_valid_next = 1'b0;
                                rem_next       = count_reg;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            rsp_status_next = pol_pkg::ST_BADPOS;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    ctl.mode        = pol_pkg::MODE_ROTATE;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = pol_pkg::ST_OK;
                    rsp_value_next  = cells[0];
                    rsp_count_next  = count_reg;
                    rsp_last_next   = (rem_reg == pol_pkg::CNT_W'(1));
                    rem_next        = rem_reg - pol_pkg::CNT_W'(1);
                    if (rem_reg == pol_pkg::CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_last_reg   <= rsp_last_next;
    end

    for (genvar i = 0; i < pol_pkg::CAPACITY; i++)
    begin : g_cell
        logic [pol_pkg::DATA_W-1:0] left_data;
        logic [pol_pkg::DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = req.value;
        end
        else
        begin : g_mid_l
            assign left_data = cells[i-1];
        end

        if (i == pol_pkg::CAPACITY - 1)
        begin : g_last
            assign right_data = cells[i];
        end
        else
        begin : g_mid_r
            assign right_data = cells[i+1];
        end

        pol_cell u_cell
        (
            .clk   (clk),
            .ctl   (ctl),
            .index (pol_pkg::IDX_W'(i)),
            .left  (left_data),
            .right (right_data),
            .head  (cells[0]),
            .data  (cells[i])
        );
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.entry_value   = rsp_value_reg;
    assign rsp.element_count = pol_pkg::ECNT_W'(rsp_count_reg);
    assign rsp.last_result   = rsp_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
        else $error("list count above capacity");

    a_dump_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> rem_reg != '0 && rem_reg <= count_reg)
        else $error("dump counter out of range");

    a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |=> count_reg == $past(count_reg))
        else $error("count changed during dump");

    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> !req.ready)
        else $error("request taken during dump");

endmodule
